// File: hw/rtl/fpba_pkg.sv
// Package for the fit-policy block allocator.
// Table sizes, field widths, register codes, controller types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

    localparam int BLOCK_SLOTS = 16;
    localparam int SIZE_BITS   = 16;

    localparam int IDX_BITS = $clog2(BLOCK_SLOTS);
    localparam int CNT_BITS = $clog2(BLOCK_SLOTS + 1);

    localparam int MODE_W     = 1;
    localparam int IN_IDX_W   = 4;
    localparam int IN_SIZE_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int POLICY_W   = 2;
    localparam int COUNT_W    = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    localparam logic [POLICY_W-1:0] POLICY_RST = POL_FIRST;
    localparam logic [COUNT_W-1:0]  COUNT_RST  = 5'd16;

    localparam logic [MODE_W-1:0] MODE_LOAD    = 1'b0;
    localparam logic [MODE_W-1:0] MODE_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_GRANT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic grant;
    } t_cmd;

    typedef struct packed {
        logic limit_zero;
        logic last;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

// File: hw/rtl/fpba_ifs.sv
// Handshake channels of the allocator: input word, result word, config write.
// Depends on fpba_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface fpba_in_if import fpba_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [IN_IDX_W-1:0]  block_index;
    logic [IN_SIZE_W-1:0] size;

    modport source (output valid, output mode, output block_index, output size, input ready);
    modport sink   (input valid, input mode, input block_index, input size, output ready);
endinterface

interface fpba_out_if import fpba_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [IN_IDX_W-1:0]  granted_block;
    logic [IN_SIZE_W-1:0] size_before;

    modport source (output valid, output found, output granted_block, output size_before,
                    input ready);
    modport sink   (input valid, input found, input granted_block, input size_before,
                    output ready);
endinterface

interface fpba_cfg_if import fpba_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fpba_ctrl.sv
// Allocator controller: accepts words, sequences the scan and the grant.
// Depends on fpba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpba_ctrl import fpba_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire [MODE_W-1:0]  i_in_mode,
    input  t_sts              i_sts,
    output logic              o_in_ready,
    output t_cmd              o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_mode == MODE_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_sts.limit_zero) begin
                    n_state = ST_GRANT;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_sts.last) begin
                        n_state = ST_GRANT;
                    end
                end
            end
            ST_GRANT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.grant = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/fpba_dpath.sv
// Allocator datapath: size table, taken marks, config registers, scan
// registers and the result register. Depends on fpba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpba_dpath import fpba_pkg::*; (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_valid,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire [IN_IDX_W-1:0]    i_in_block_index,
    input  wire [IN_SIZE_W-1:0]   i_in_size,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  wire                   i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_out_found,
    output logic [IN_IDX_W-1:0]   o_out_granted_block,
    output logic [IN_SIZE_W-1:0]  o_out_size_before
);

    localparam int CMP_W = (SIZE_BITS > IN_SIZE_W) ? SIZE_BITS : IN_SIZE_W;

    logic [SIZE_BITS-1:0]   r_sizes [BLOCK_SLOTS];
    logic [BLOCK_SLOTS-1:0] r_taken;

    logic [POLICY_W-1:0]  r_policy;
    logic [COUNT_W-1:0]   r_block_count;

    logic [IN_SIZE_W-1:0] r_req;
    logic [CNT_BITS-1:0]  r_limit;
    logic [CNT_BITS-1:0]  r_k;
    logic                 r_hit;
    logic [IDX_BITS-1:0]  r_pick;
    logic [SIZE_BITS-1:0] r_best;

    logic                 r_out_valid;
    logic                 r_out_found;
    logic [IN_IDX_W-1:0]  r_out_block;
    logic [IN_SIZE_W-1:0] r_out_size;

    logic [IDX_BITS-1:0]  k_idx;
    logic [SIZE_BITS-1:0] cur_size;
    logic [CMP_W-1:0]     cur_x;
    logic [CMP_W-1:0]     best_x;
    logic [CMP_W-1:0]     req_x;
    logic                 fits;
    logic                 ff_take;
    logic                 take;
    logic                 load_ok;
    logic [IDX_BITS-1:0]  load_idx;
    logic [CNT_BITS-1:0]  limit_n;
    logic [CNT_BITS:0]    k_next;

    assign k_idx    = r_k[IDX_BITS-1:0];
    assign cur_size = r_sizes[k_idx];
    assign cur_x    = CMP_W'(cur_size);
    assign best_x   = CMP_W'(r_best);
    assign req_x    = CMP_W'(r_req);
    assign fits     = (cur_x >= req_x);
    assign ff_take  = (r_policy == POL_FIRST) && fits && !r_taken[k_idx];
    assign load_ok  = (32'(i_in_block_index) < 32'(BLOCK_SLOTS));
    assign load_idx = IDX_BITS'(i_in_block_index);
    assign limit_n  = (32'(r_block_count) > 32'(BLOCK_SLOTS)) ? CNT_BITS'(BLOCK_SLOTS)
                                                              : CNT_BITS'(r_block_count);
    assign k_next   = (CNT_BITS+1)'(r_k) + (CNT_BITS+1)'(1);

    always_comb begin
        case (r_policy)
            POL_FIRST: take = ff_take && !r_hit;
            POL_BEST:  take = fits && (!r_hit || (cur_x < best_x));
            POL_WORST: take = fits && (!r_hit || (cur_x > best_x));
            default:   take = 1'b0;
        endcase
    end

    assign o_sts.limit_zero = (r_limit == '0);
    assign o_sts.last       = (k_next >= (CNT_BITS+1)'(r_limit)) || ff_take;
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy      <= POLICY_RST;
            r_block_count <= COUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POLICY:      r_policy      <= i_cfg_data[POLICY_W-1:0];
                CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[COUNT_W-1:0];
                default:         r_policy      <= r_policy;
            endcase
        end
    end

    // size table, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && load_ok) begin
            r_sizes[load_idx] <= SIZE_BITS'(i_in_size);
        end else if (i_cmd.grant && r_hit && (r_policy != POL_FIRST)) begin
            r_sizes[r_pick] <= SIZE_BITS'(best_x - req_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
        end else if (i_cmd.load && load_ok) begin
            r_taken[load_idx] <= 1'b0;
        end else if (i_cmd.grant && r_hit && (r_policy == POL_FIRST)) begin
            r_taken[r_pick] <= 1'b1;
        end
    end

    // scan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_k   <= '0;
        end else if (i_cmd.start) begin
            r_hit <= 1'b0;
            r_k   <= '0;
        end else if (i_cmd.step) begin
            r_k <= k_next[CNT_BITS-1:0];
            if (take) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req   <= i_in_size;
            r_limit <= limit_n;
        end
        if (i_cmd.step && take) begin
            r_pick <= k_idx;
            r_best <= cur_size;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.grant) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grant) begin
            r_out_found <= r_hit;
            r_out_block <= r_hit ? IN_IDX_W'(r_pick) : '0;
            r_out_size  <= r_hit ? IN_SIZE_W'(r_best) : '0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_found         = r_out_found;
    assign o_out_granted_block = r_out_block;
    assign o_out_size_before   = r_out_size;

endmodule

`default_nettype wire

// File: hw/rtl/fit_policy_block_allocator_core.sv
// Top level of the fit-policy block allocator: controller plus datapath.
// Depends on fpba_pkg, fpba_ifs, fpba_ctrl, fpba_dpath.
//
//   channel  dir  fields                          word accepted when
//   i_in     in   mode, block_index, size         i_in.valid & i_in.ready
//   o_out    out  found, granted_block, size_before o_out.valid & o_out.ready
//   i_cfg    in   index, data                     i_cfg.valid (ready tied high)
//
// Load word: written to the table when accepted, no result. Request word: accepted,
// then one scan step per block (min(block_count,16), none when block_count is 0; first
// fit stops at its hit), then the grant. The scan reads one table entry per cycle.
// Reset clears the taken marks and config; sizes are undefined until loaded.
// A result waiting in the output register holds the next grant, and the input with it.
`timescale 1ns / 1ps
`default_nettype none

module fit_policy_block_allocator_core import fpba_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    fpba_in_if.sink     i_in,
    fpba_out_if.source  o_out,
    fpba_cfg_if.sink    i_cfg
);

    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    fpba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_mode  (i_in.mode),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    fpba_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg.valid),
        .i_cfg_index         (i_cfg.index),
        .i_cfg_data          (i_cfg.data),
        .i_in_block_index    (i_in.block_index),
        .i_in_size           (i_in.size),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_out_ready         (o_out.ready),
        .o_out_valid         (o_out.valid),
        .o_out_found         (o_out.found),
        .o_out_granted_block (o_out.granted_block),
        .o_out_size_before   (o_out.size_before)
    );

endmodule

`default_nettype wire

// File: hw/rtl/fpba_checker.sv
// Port-level checks for the allocator, bound to the top level.
// Depends on fpba_pkg and fit_policy_block_allocator_core.
`timescale 1ns / 1ps
`default_nettype none

module fpba_checker import fpba_pkg::*; (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  i_in_ready,
    input wire [MODE_W-1:0]     i_in_mode,
    input wire                  i_out_valid,
    input wire                  i_out_ready,
    input wire                  i_out_found,
    input wire [IN_IDX_W-1:0]   i_out_granted_block,
    input wire [IN_SIZE_W-1:0]  i_out_size_before
);

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_found) |-> (i_out_granted_block == '0 &&
                                           i_out_size_before == '0))
        else $error("miss word carries nonzero fields");

    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_mode == MODE_REQUEST) |=> !i_in_ready)
        else $error("input ready during request scan");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result word without a request in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_found) &&
            $stable(i_out_granted_block) && $stable(i_out_size_before)))
        else $error("stalled result word changed");

endmodule

bind fit_policy_block_allocator_core fpba_checker u_fpba_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_in_mode           (i_in.mode),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_found         (o_out.found),
    .i_out_granted_block (o_out.granted_block),
    .i_out_size_before   (o_out.size_before)
);

`default_nettype wire

// File: sim/fpba_grant_checker.sv
// Scoreboard for the fit-policy block allocator: watches the input, result and
// config channels, keeps its own block table and checks every result word.
// Depends on fpba_pkg and fpba_ifs.
`timescale 1ns / 1ps

module fpba_grant_checker import fpba_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    fpba_in_if   in_ch,
    fpba_out_if  out_ch,
    fpba_cfg_if  cfg_ch,
    output int   o_errors,
    output int   o_pending
);

    typedef struct packed {
        logic                 found;
        logic [IN_IDX_W-1:0]  blk;
        logic [IN_SIZE_W-1:0] size_before;
    } grant_t;

    logic [SIZE_BITS-1:0] blk_size  [BLOCK_SLOTS];
    logic                 blk_taken [BLOCK_SLOTS];
    logic [POLICY_W-1:0]  policy;
    logic [COUNT_W-1:0]   count;
    grant_t               grants_due [$];
    int                   err_cnt = 0;

    // Works out one request against the table and applies the grant.
    function automatic grant_t predict_grant(input logic [IN_SIZE_W-1:0] req);
        grant_t g;
        int     scan;
        int     pick;
        bit     hit;
        bit     done;
        g    = '0;
        pick = 0;
        hit  = 1'b0;
        done = 1'b0;
        scan = (count > BLOCK_SLOTS) ? BLOCK_SLOTS : int'(count);
        for (int k = 0; k < scan; k++) begin
            if (!done && blk_size[k] >= req) begin
                case (policy)
                    POL_FIRST: begin
                        if (!blk_taken[k]) begin
                            hit  = 1'b1;
                            pick = k;
                            done = 1'b1;
                        end
                    end
                    POL_BEST: begin
                        if (!hit || blk_size[k] < blk_size[pick]) begin
                            hit  = 1'b1;
                            pick = k;
                        end
                    end
                    POL_WORST: begin
                        if (!hit || blk_size[k] > blk_size[pick]) begin
                            hit  = 1'b1;
                            pick = k;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (hit) begin
            g.found       = 1'b1;
            g.blk         = pick[IN_IDX_W-1:0];
            g.size_before = blk_size[pick];
            if (policy == POL_FIRST)
                blk_taken[pick] = 1'b1;
            else
                blk_size[pick] = blk_size[pick] - req;
        end
        return g;
    endfunction

    always @(posedge i_clk) begin : watch
        grant_t want;
        grant_t got;
        if (!i_rst_n) begin
            for (int k = 0; k < BLOCK_SLOTS; k++)
                blk_taken[k] = 1'b0;
            policy = POLICY_RST;
            count  = COUNT_RST;
            grants_due.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.found, out_ch.granted_block, out_ch.size_before};
                if (grants_due.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result word with nothing expected: found %0d block %0d size %0d",
                             $time, got.found, got.blk, got.size_before);
                end else begin
                    want = grants_due.pop_front();
                    if (got.found !== want.found) begin
                        err_cnt++;
                        $display("%0t: found expected %0d actual %0d",
                                 $time, want.found, got.found);
                    end
                    if (got.blk !== want.blk) begin
                        err_cnt++;
                        $display("%0t: granted_block expected %0d actual %0d",
                                 $time, want.blk, got.blk);
                    end
                    if (got.size_before !== want.size_before) begin
                        err_cnt++;
                        $display("%0t: size_before expected %0d actual %0d",
                                 $time, want.size_before, got.size_before);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.mode == MODE_LOAD) begin
                    blk_size[in_ch.block_index]  = in_ch.size;
                    blk_taken[in_ch.block_index] = 1'b0;
                end else begin
                    grants_due.push_back(predict_grant(in_ch.size));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_POLICY:      policy = cfg_ch.data[POLICY_W-1:0];
                    CFG_BLOCK_COUNT: count  = cfg_ch.data[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_errors  <= err_cnt;
        o_pending <= grants_due.size();
    end

endmodule

// File: sim/tb_fit_policy_block_allocator_core.sv
// Testbench top for fit_policy_block_allocator_core: drives load/request words
// in bursts, walks the policy and block count registers, throttles the result side.
// Depends on fpba_pkg, fpba_ifs, the core RTL and fpba_grant_checker.
`timescale 1ns / 1ps

module tb_fit_policy_block_allocator_core;
    import fpba_pkg::*;

    localparam int DRAIN_CYCLES   = 24;
    localparam int STALL_LIMIT    = 4000;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int PHASES         = 14;
    localparam int PHASE_ITEMS    = 38;
    localparam int PROBES         = 6;

    localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fpba_in_if  in_ch ();
    fpba_out_if out_ch ();
    fpba_cfg_if cfg_ch ();

    int errors;
    int pending;
    int burst_left   = 1;
    int n_loads      = 0;
    int n_requests   = 0;
    int n_settings   = 0;
    int squeeze_asks = 0;
    int squeeze_done = 0;
    int quiet_cycles = 0;

    logic [IN_SIZE_W-1:0] loaded_size [BLOCK_SLOTS];

    logic [IN_SIZE_W-1:0] preset_sizes [BLOCK_SLOTS] = '{
        16'h0000, 16'h0001, 16'hFFFF, 16'd100, 16'h8000, 16'd50, 16'h0000, 16'd200,
        16'h7FFF, 16'd3, 16'd1000, 16'hFFFE, 16'd7, 16'h5555, 16'hAAAA, 16'd20
    };
    logic [IN_SIZE_W-1:0] probe_sizes [PROBES] = '{
        16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h0001
    };

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    fit_policy_block_allocator_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    fpba_grant_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_ch    (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) ||
            (out_ch.valid && out_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("fit_policy_block_allocator_core: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: stall patterns of random style and length, plus long hold-offs on request.
    initial begin : receiver
        int span;
        int style;
        int tick;
        out_ch.ready <= 1'b0;
        tick = 0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            if (squeeze_asks > squeeze_done) begin
                out_ch.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
                squeeze_done++;
            end
            style = $urandom_range(0, 3);
            span  = $urandom_range(8, 60);
            repeat (span) begin
                case (style)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ch.ready <= ($urandom_range(0, 1) != 0);
                    default: out_ch.ready <= ((tick % 5) < 2);
                endcase
                tick++;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_word(input logic [MODE_W-1:0] m, input logic [IN_IDX_W-1:0] bi,
                             input logic [IN_SIZE_W-1:0] sz);
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= m;
        in_ch.block_index <= bi;
        in_ch.size        <= sz;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        if (m == MODE_LOAD) begin
            n_loads++;
            loaded_size[bi] = sz;
        end else begin
            n_requests++;
        end
        burst_left--;
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
        end
    endtask

    // Stop offering, let every result arrive, then give a trailing load time to finish.
    task automatic settle();
        in_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] pol_data,
                              input logic [CFG_DATA_W-1:0] cnt_data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_POLICY;
        cfg_ch.data  <= pol_data;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        cfg_ch.index <= CFG_BLOCK_COUNT;
        cfg_ch.data  <= cnt_data;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    initial begin : stimulus
        logic [POLICY_W-1:0]   pol;
        logic [COUNT_W-1:0]    cnt;
        logic [CFG_DATA_W-1:0] pol_data;
        logic [IN_IDX_W-1:0]   bi;
        logic [IN_SIZE_W-1:0]  sz;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.mode        <= MODE_LOAD;
        in_ch.block_index <= '0;
        in_ch.size        <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_POLICY;
        cfg_ch.data       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill the whole table under reset settings, then probe first fit.
        for (int k = 0; k < BLOCK_SLOTS; k++)
            send_word(MODE_LOAD, k[IN_IDX_W-1:0], preset_sizes[k]);
        for (int k = 0; k < PROBES; k++)
            send_word(MODE_REQUEST, IN_IDX_W'($urandom_range(0, 15)), probe_sizes[k]);
        send_word(MODE_LOAD, 4'd2, 16'hFFFF);
        send_word(MODE_REQUEST, 4'd15, 16'hFFFF);
        send_word(MODE_REQUEST, 4'd0, 16'hFFFE);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            pol_data = '0;
            case (ph)
                0:       begin pol = POL_BEST;   cnt = 5'd1;  end
                1:       begin pol = POL_WORST;  cnt = 5'd16; end
                2:       begin pol = POL_FIRST;  cnt = 5'd0;  end
                3:       begin pol = POL_UNUSED; cnt = 5'd16; end
                4:       begin pol = POL_BEST;   cnt = 5'd31; end
                5:       begin pol = POL_WORST;  cnt = 5'd17; end
                6:       begin pol = POL_FIRST;  cnt = 5'd1;  end
                default: begin
                    pol = ($urandom_range(0, 9) == 0) ? POL_UNUSED
                                                      : POLICY_W'($urandom_range(0, 2));
                    case ($urandom_range(0, 9))
                        0:       cnt = 5'd0;
                        1:       cnt = COUNT_W'($urandom_range(17, 31));
                        default: cnt = COUNT_W'($urandom_range(1, 16));
                    endcase
                    if ($urandom_range(0, 1) != 0)
                        pol_data[CFG_DATA_W-1:POLICY_W] = 3'($urandom_range(0, 7));
                end
            endcase
            pol_data[POLICY_W-1:0] = pol;
            write_regs(pol_data, cnt);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ((ph == 1 || ph == 9) && n == 10)
                    squeeze_asks++;
                bi = IN_IDX_W'($urandom_range(0, 15));
                if ($urandom_range(0, 9) < 3) begin
                    case ($urandom_range(0, 4))
                        0:       sz = IN_SIZE_W'($urandom_range(0, 1023));
                        1:       sz = '1;
                        2:       sz = '0;
                        default: sz = IN_SIZE_W'($urandom);
                    endcase
                    send_word(MODE_LOAD, bi, sz);
                end else begin
                    case ($urandom_range(0, 9))
                        0:       sz = '0;
                        1:       sz = '1;
                        2, 3:    sz = IN_SIZE_W'($urandom);
                        4, 5:    sz = IN_SIZE_W'($urandom_range(0, 255));
                        default: sz = loaded_size[$urandom_range(0, 15)] >> $urandom_range(0, 2);
                    endcase
                    send_word(MODE_REQUEST, bi, sz);
                end
            end
        end
        settle();

        $display("covered %0d load and %0d request words over %0d register settings",
                 n_loads, n_requests, n_settings);
        $display("all four policy codes, block counts 0/1/16/17/31 and random, %0d long stalls",
                 squeeze_done);
        if (errors == 0)
            $display("fit_policy_block_allocator_core: match");
        else
            $display("fit_policy_block_allocator_core: mismatch");
        $finish;
    end

endmodule
